// File: src/lpr_pkg.sv
// shared types and constants for the lru page replacement core
// no dependencies; imported by the scan unit, the top level and the testbench

package lpr_pkg;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

    // outcome of one scan over the active frames
    typedef struct packed {
        logic found;
        logic empty;
    } t_scan_flags;

    // register map, decoded on paddr[2]
    localparam int          APB_ADDR_W        = 3;
    localparam int          APB_DATA_W        = 32;
    localparam logic [0:0]  REG_FRAMES_IN_USE = 1'b0;

    localparam int          FIU_W             = 4;
    localparam logic [3:0]  FIU_RESET         = 4'd8;

    localparam int          FAULT_W           = 32;
    localparam logic [31:0] FAULT_MAX         = 32'hFFFF_FFFF;

    // fixed widths of the result fields
    localparam int          OUT_PAGE_W        = 16;
    localparam int          OUT_IDX_W         = 3;

endpackage

// File: src/lru_page_replacement_core.sv
// lru page replacement core: frame table, sequencer, recency ranks, fault counter
// depends on lpr_pkg, lpr_frame_mem and lpr_scan_unit

// Each page reference is looked up in a fully associative table of frames; the
// first frames_in_use frames (0 acts as 1, anything above FRAMES as FRAMES) take
// part. One compare unit walks the active frames one per cycle through the single
// read port of the page store, finding the hit, the first empty frame and the
// least recently used frame in one pass. An item passes from acceptance through
// the scan state, which reads each active frame and takes the last read data, to
// the update state, which waits while a held result stalls the output. The result
// sits in an output register, so the next reference is taken while it waits.
// Frame valid bits and ranks clear at reset; no clearing pass is needed.
// frames_in_use is meant to be written only while the core is idle.

module lru_page_replacement_core #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // reference channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [15:0]                         i_page_number,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_hit,
    output logic [lpr_pkg::OUT_IDX_W-1:0]       o_frame_index,
    output logic                                o_evicted_valid,
    output logic [lpr_pkg::OUT_PAGE_W-1:0]      o_evicted_page,
    output logic [lpr_pkg::FAULT_W-1:0]         o_fault_total,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lpr_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [lpr_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [lpr_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    import lpr_pkg::*;

    localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int RW = IW;
    localparam int CW = $clog2(FRAMES + 1);
    localparam int PW = PAGE_BITS;
    localparam logic [RW-1:0] RANK_MAX = RW'(FRAMES - 1);

    t_state            r_state;
    t_state            n_state;

    logic [FIU_W-1:0]  r_fiu;
    logic [CW-1:0]     r_act;
    logic [CW-1:0]     r_idx;
    logic              r_cmp_vld;
    logic [IW-1:0]     r_cmp_idx;
    logic [PW-1:0]     r_page;

    logic [FRAMES-1:0] r_valid;
    logic [RW-1:0]     r_rank  [FRAMES];
    logic [FAULT_W-1:0] r_fault_cnt;

    logic              r_out_vld;
    logic              r_out_hit;
    logic [OUT_IDX_W-1:0]  r_out_idx;
    logic              r_out_ev_vld;
    logic [OUT_PAGE_W-1:0] r_out_ev_page;
    logic [FAULT_W-1:0]    r_out_fault;

    logic              w_accept;
    logic              w_rd_en;
    logic              w_commit;
    logic              w_cfg_wr;
    logic [31:0]       w_fiu_wide;
    logic [CW-1:0]     w_act;
    logic [PW+15:0]    w_page_ext;
    logic [PW-1:0]     w_mem_rdata;

    t_scan_flags       w_flags;
    logic [IW-1:0]     w_hit_idx;
    logic [RW-1:0]     w_hit_rank;
    logic [IW-1:0]     w_empty_idx;
    logic [IW-1:0]     w_old_idx;
    logic [PW-1:0]     w_old_page;

    logic              w_miss;
    logic              w_evict;
    logic [IW-1:0]     w_sel;
    logic [FAULT_W-1:0] n_fault;
    logic [IW+2:0]     w_sel_ext;
    logic [PW+15:0]    w_ev_ext;

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fiu <= FIU_RESET;
        end else if (w_cfg_wr && (paddr[2:2] == REG_FRAMES_IN_USE)) begin
            r_fiu <= pwdata[FIU_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2:2] == REG_FRAMES_IN_USE) begin
            prdata = {{(APB_DATA_W-FIU_W){1'b0}}, r_fiu};
        end
    end

    // clamp the frame count
    assign w_fiu_wide = 32'(r_fiu);
    always_comb begin
        if (r_fiu == '0) begin
            w_act = CW'(1);
        end else if (w_fiu_wide > 32'(FRAMES)) begin
            w_act = CW'(FRAMES);
        end else begin
            w_act = CW'(r_fiu);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx == r_act) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_vld || !i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_rd_en    = 1'b0;
        w_commit   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                // hold off beats while reset is applied
                o_in_stall = !i_rst_n;
                w_accept   = i_in_valid && i_rst_n;
            end
            ST_SCAN: begin
                w_rd_en = (r_idx < r_act);
            end
            ST_DONE: begin
                w_commit = !r_out_vld || !i_out_stall;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign w_page_ext = {{PW{1'b0}}, i_page_number};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= w_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_page <= w_page_ext[PW-1:0];
            r_act  <= w_act;
            r_idx  <= '0;
        end else if (w_rd_en) begin
            r_idx <= r_idx + CW'(1);
        end
        r_cmp_idx <= r_idx[IW-1:0];
    end

    lpr_frame_mem #(
        .DEPTH (FRAMES),
        .AW    (IW),
        .DW    (PW)
    ) u_frame_mem (
        .i_clk   (i_clk),
        .i_we    (w_commit && w_miss),
        .i_waddr (w_sel),
        .i_wdata (r_page),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (w_mem_rdata)
    );

    lpr_scan_unit #(
        .IW (IW),
        .RW (RW),
        .PW (PW)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_accept),
        .i_step      (r_cmp_vld),
        .i_idx       (r_cmp_idx),
        .i_valid     (r_valid[r_cmp_idx]),
        .i_rank      (r_rank[r_cmp_idx]),
        .i_ref_page  (r_page),
        .i_mem_page  (w_mem_rdata),
        .o_flags     (w_flags),
        .o_hit_idx   (w_hit_idx),
        .o_hit_rank  (w_hit_rank),
        .o_empty_idx (w_empty_idx),
        .o_old_idx   (w_old_idx),
        .o_old_page  (w_old_page)
    );

    // pick the frame from the scan outcome
    assign w_miss  = !w_flags.found;
    assign w_evict = w_miss && !w_flags.empty;

    always_comb begin
        if (w_flags.found) begin
            w_sel = w_hit_idx;
        end else if (w_flags.empty) begin
            w_sel = w_empty_idx;
        end else begin
            w_sel = w_old_idx;
        end
    end

    assign n_fault   = (w_miss && (r_fault_cnt != FAULT_MAX)) ?
                       r_fault_cnt + FAULT_W'(1) : r_fault_cnt;
    assign w_sel_ext = {3'b000, w_sel};
    assign w_ev_ext  = {16'h0000, w_old_page};

    // frame state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < FRAMES; j++) begin
                r_valid[j] <= 1'b0;
                r_rank[j]  <= '0;
            end
            r_fault_cnt <= '0;
        end else if (w_commit) begin
            for (int j = 0; j < FRAMES; j++) begin
                if (IW'(j) == w_sel) begin
                    r_rank[j] <= '0;
                    if (w_miss) begin
                        r_valid[j] <= 1'b1;
                    end
                // other frames age by one; on a hit only those more recent
                end else if ((CW'(j) < r_act) && r_valid[j] &&
                             (w_miss || (r_rank[j] < w_hit_rank)) &&
                             (r_rank[j] != RANK_MAX)) begin
                    r_rank[j] <= r_rank[j] + RW'(1);
                end
            end
            r_fault_cnt <= n_fault;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_commit) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_hit     <= w_flags.found;
            r_out_idx     <= w_sel_ext[OUT_IDX_W-1:0];
            r_out_ev_vld  <= w_evict;
            r_out_ev_page <= w_evict ? w_ev_ext[OUT_PAGE_W-1:0] : '0;
            r_out_fault   <= n_fault;
        end
    end

    assign o_out_valid     = r_out_vld;
    assign o_hit           = r_out_hit;
    assign o_frame_index   = r_out_idx;
    assign o_evicted_valid = r_out_ev_vld;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_total   = r_out_fault;

`ifndef NO_ASSERTIONS
    // a fault below saturation bumps the counter by exactly one
    a_fault_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_miss && (r_fault_cnt != FAULT_MAX))
        |=> (r_fault_cnt == $past(r_fault_cnt) + FAULT_W'(1)))
        else $error("fault counter did not advance on a miss");

    // the touched frame ends up valid and most recent
    a_sel_recent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_commit |=> (r_valid[$past(w_sel)] && (r_rank[$past(w_sel)] == '0)))
        else $error("selected frame not valid and most recent");

    // a hit never changes which frames are filled
    a_hit_keeps_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_flags.found)
        |=> ($countones(r_valid) == $countones($past(r_valid))))
        else $error("frame fill changed on a hit");

    // a result beat is loaded only once the previous one has gone
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && r_out_vld) |-> !i_out_stall)
        else $error("result overwritten while stalled");
`endif

endmodule

// File: src/lpr_frame_mem.sv
// page number store, one entry per frame, one write and one read port
// registered read data; no dependencies

module lpr_frame_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/lpr_scan_unit.sv
// shared compare unit: one frame per step for hit, first empty and oldest search
// depends on lpr_pkg

module lpr_scan_unit #(
    parameter int IW = 3,
    parameter int RW = 3,
    parameter int PW = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_clear,
    input  logic                i_step,
    input  logic [IW-1:0]       i_idx,
    input  logic                i_valid,
    input  logic [RW-1:0]       i_rank,
    input  logic [PW-1:0]       i_ref_page,
    input  logic [PW-1:0]       i_mem_page,
    output lpr_pkg::t_scan_flags o_flags,
    output logic [IW-1:0]       o_hit_idx,
    output logic [RW-1:0]       o_hit_rank,
    output logic [IW-1:0]       o_empty_idx,
    output logic [IW-1:0]       o_old_idx,
    output logic [PW-1:0]       o_old_page
);

    import lpr_pkg::*;

    logic          r_found;
    logic          r_empty;
    logic          r_started;
    logic [IW-1:0] r_hit_idx;
    logic [RW-1:0] r_hit_rank;
    logic [IW-1:0] r_empty_idx;
    logic [IW-1:0] r_old_idx;
    logic [RW-1:0] r_old_rank;
    logic [PW-1:0] r_old_page;

    logic w_match;
    logic w_take_hit;
    logic w_take_empty;
    logic w_take_old;

    assign w_match      = i_valid && (i_mem_page == i_ref_page);
    assign w_take_hit   = w_match && !r_found;
    assign w_take_empty = !i_valid && !r_empty;
    // first frame always seeds the oldest candidate, later ones only if strictly older
    assign w_take_old   = !r_started || (i_rank > r_old_rank);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found   <= 1'b0;
            r_empty   <= 1'b0;
            r_started <= 1'b0;
        end else if (i_clear) begin
            r_found   <= 1'b0;
            r_empty   <= 1'b0;
            r_started <= 1'b0;
        end else if (i_step) begin
            if (w_take_hit) begin
                r_found <= 1'b1;
            end
            if (w_take_empty) begin
                r_empty <= 1'b1;
            end
            r_started <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && !i_clear) begin
            if (w_take_hit) begin
                r_hit_idx  <= i_idx;
                r_hit_rank <= i_rank;
            end
            if (w_take_empty) begin
                r_empty_idx <= i_idx;
            end
            if (w_take_old) begin
                r_old_idx  <= i_idx;
                r_old_rank <= i_rank;
                r_old_page <= i_mem_page;
            end
        end
    end

    assign o_flags.found = r_found;
    assign o_flags.empty = r_empty;
    assign o_hit_idx     = r_hit_idx;
    assign o_hit_rank    = r_hit_rank;
    assign o_empty_idx   = r_empty_idx;
    assign o_old_idx     = r_old_idx;
    assign o_old_page    = r_old_page;

endmodule

// File: tb/tb_lru_page_replacement_core.sv
// testbench for lru_page_replacement_core: a directed reference table, then random page
// streams under a series of frame counts, every result beat checked against its typed row or a frame table model
// depends on lpr_pkg and the core

module tb_lru_page_replacement_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lpr_pkg::*;

    localparam int FRAMES           = 8;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int LONG_HOLD        = 300;
    localparam int ROWS             = 22;
    localparam int POOL_MAX         = 12;
    localparam int PHASES           = 12;
    localparam int RANDOM_PER_PHASE = 103;

    // frame counts visited after the directed part; zero and above FRAMES are clamped by the core
    localparam logic [3:0] FIU_PLAN [PHASES] = '{
        4'd1, 4'd0, 4'd3, 4'd15, 4'd2, 4'd8, 4'd5, 4'd9, 4'd4, 4'd7, 4'd6, 4'd8
    };

    typedef struct packed {
        logic        hit;
        logic [2:0]  frame;
        logic        ev_valid;
        logic [15:0] ev_page;
        logic [31:0] faults;
    } t_ref_result;

    typedef struct packed {
        logic [15:0] page;
        logic        typed;
        t_ref_result want;
    } t_ref_row;

    // directed references at the reset frame count of eight
    t_ref_row ref_rows [ROWS] = '{
        '{16'h0000, 1'b1, {1'b0, 3'd0, 1'b0, 16'h0000, 32'd1}},
        '{16'hFFFF, 1'b1, {1'b0, 3'd1, 1'b0, 16'h0000, 32'd2}},
        '{16'h0000, 1'b1, {1'b1, 3'd0, 1'b0, 16'h0000, 32'd2}},
        '{16'h5555, 1'b1, {1'b0, 3'd2, 1'b0, 16'h0000, 32'd3}},
        '{16'hAAAA, 1'b1, {1'b0, 3'd3, 1'b0, 16'h0000, 32'd4}},
        '{16'h0001, 1'b1, {1'b0, 3'd4, 1'b0, 16'h0000, 32'd5}},
        '{16'h8000, 1'b1, {1'b0, 3'd5, 1'b0, 16'h0000, 32'd6}},
        '{16'h7FFF, 1'b1, {1'b0, 3'd6, 1'b0, 16'h0000, 32'd7}},
        '{16'h1234, 1'b1, {1'b0, 3'd7, 1'b0, 16'h0000, 32'd8}},
        // table full: frame 1 is the least recent after the hit on frame 0
        '{16'h4321, 1'b1, {1'b0, 3'd1, 1'b1, 16'hFFFF, 32'd9}},
        '{16'h8000, 1'b1, {1'b1, 3'd5, 1'b0, 16'h0000, 32'd9}},
        '{16'h8000, 1'b1, {1'b1, 3'd5, 1'b0, 16'h0000, 32'd9}},
        '{16'hFFFF, 1'b0, '0},
        '{16'h0001, 1'b0, '0},
        '{16'h4321, 1'b0, '0},
        '{16'hDEAD, 1'b0, '0},
        '{16'h0000, 1'b0, '0},
        '{16'h5555, 1'b0, '0},
        '{16'hBEEF, 1'b0, '0},
        '{16'h1234, 1'b0, '0},
        '{16'hFFFE, 1'b0, '0},
        '{16'h0002, 1'b0, '0}
    };

    logic                     i_clk;
    logic                     i_rst_n         = 1'b0;
    logic                     i_in_valid      = 1'b0;
    logic                     o_in_stall;
    logic [15:0]              i_page_number   = '0;
    logic                     o_out_valid;
    logic                     i_out_stall     = 1'b0;
    logic                     o_hit;
    logic [OUT_IDX_W-1:0]     o_frame_index;
    logic                     o_evicted_valid;
    logic [OUT_PAGE_W-1:0]    o_evicted_page;
    logic [FAULT_W-1:0]       o_fault_total;
    logic                     psel            = 1'b0;
    logic                     penable         = 1'b0;
    logic                     pwrite          = 1'b0;
    logic [APB_ADDR_W-1:0]    paddr           = '0;
    logic [APB_DATA_W-1:0]    pwdata          = '0;
    logic [APB_DATA_W-1:0]    prdata;
    logic                     pready;

    lru_page_replacement_core #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (16)
    ) dut (.*);

    // frame table as the core should hold it
    logic [15:0]  tbl_page [FRAMES];
    logic         tbl_full [FRAMES];
    logic [2:0]   tbl_age  [FRAMES];
    logic [31:0]  fault_count;
    logic [3:0]   fiu_reg;

    t_ref_result  pending_results [$];
    int           mismatches  = 0;
    int           tx_idle_pct = 0;
    int           rx_idle_pct = 0;
    int           holds_asked = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("[%0t] mismatch %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    function automatic int active_frames();
        if (fiu_reg == 4'd0)
            return 1;
        if (fiu_reg > FRAMES)
            return FRAMES;
        return int'(fiu_reg);
    endfunction

    // frame sel becomes most recent; frames younger than its old age grow older by one
    function automatic void make_recent(int sel, int old_age, int act);
        for (int j = 0; j < act; j++) begin
            if (j != sel && tbl_full[j] && tbl_age[j] < old_age && tbl_age[j] < FRAMES - 1)
                tbl_age[j]++;
        end
        tbl_age[sel] = '0;
    endfunction

    function automatic t_ref_result resolve_ref(logic [15:0] pg);
        t_ref_result r;
        int          act;
        int          sel;
        int          oldest;
        logic        found;
        logic        empty;
        act   = active_frames();
        sel   = 0;
        found = 1'b0;
        empty = 1'b0;
        r     = '0;
        for (int j = 0; j < act; j++) begin
            if (!found && tbl_full[j] && tbl_page[j] == pg) begin
                sel   = j;
                found = 1'b1;
            end
        end
        if (found) begin
            make_recent(sel, tbl_age[sel], act);
        end else begin
            for (int j = 0; j < act; j++) begin
                if (!empty && !tbl_full[j]) begin
                    sel   = j;
                    empty = 1'b1;
                end
            end
            if (!empty) begin
                // lowest-numbered frame wins a tie for oldest
                oldest = 0;
                sel    = 0;
                for (int j = 0; j < act; j++) begin
                    if (tbl_age[j] > oldest) begin
                        oldest = tbl_age[j];
                        sel    = j;
                    end
                end
                r.ev_valid = 1'b1;
                r.ev_page  = tbl_page[sel];
            end
            tbl_page[sel] = pg;
            tbl_full[sel] = 1'b1;
            make_recent(sel, FRAMES, act);
            if (fault_count != FAULT_MAX)
                fault_count++;
        end
        r.hit    = found;
        r.frame  = 3'(sel);
        r.faults = fault_count;
        return r;
    endfunction

    // offer one reference, optionally after an idle gap, and log its expected result beat
    task automatic send_ref(input logic [15:0] pg, input logic typed, input t_ref_result want);
        t_ref_result predicted;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= pg;
        do @(posedge i_clk); while (o_in_stall);
        predicted = resolve_ref(pg);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // write the frame count, then read it back
    task automatic set_frames_in_use(input logic [3:0] val);
        logic [APB_DATA_W-1:0] word;
        word           = $urandom;
        word[FIU_W-1:0] = val;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_FRAMES_IN_USE, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        fiu_reg = val;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[FIU_W-1:0] !== val)
            report_mismatch("frames_in_use readback", prdata[FIU_W-1:0], val);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // result side: random stall, or a long hold when one is asked for
    initial begin
        int holds_done;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (holds_asked != holds_done) begin
                holds_done++;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_ref_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", o_fault_total, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch("hit", o_hit, want.hit);
                if (o_frame_index !== want.frame)
                    report_mismatch("frame_index", o_frame_index, want.frame);
                if (o_evicted_valid !== want.ev_valid)
                    report_mismatch("evicted_valid", o_evicted_valid, want.ev_valid);
                if (o_evicted_page !== want.ev_page)
                    report_mismatch("evicted_page", o_evicted_page, want.ev_page);
                if (o_fault_total !== want.faults)
                    report_mismatch("fault_total", o_fault_total, want.faults);
            end
        end
    end

    initial begin
        int cycles_run;
        cycles_run = 0;
        while (cycles_run < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles_run++;
        end
        $display("timeout after %0d cycles, %0d beats pending", CYCLE_LIMIT,
                 pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int          pool_sz;
        logic [15:0] pool [POOL_MAX];
        logic [15:0] pg;
        fault_count = '0;
        fiu_reg     = FIU_RESET;
        foreach (tbl_full[j]) begin
            tbl_full[j] = 1'b0;
            tbl_age[j]  = '0;
        end
        foreach (pool[j])
            pool[j] = 16'($urandom);
        tx_idle_pct = 27;
        rx_idle_pct = 66;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < ROWS; r++)
            send_ref(ref_rows[r].page, ref_rows[r].typed, ref_rows[r].want);
        i_in_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 66;
                rx_idle_pct = 27;
            end
            if (ph == 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            set_frames_in_use(FIU_PLAN[ph]);
            // a small page pool keeps hits frequent; at least half of it survives so that old
            // frames hit again when the count grows
            pool_sz = active_frames() + 3;
            for (int j = 0; j < POOL_MAX / 2; j++)
                pool[$urandom_range(0, POOL_MAX - 1)] = 16'($urandom);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (ph == 4 && n == 40)
                    holds_asked++;
                if (ph == 6 && n == 50) begin
                    i_in_valid <= 1'b0;
                    wait_drained();
                end
                case ($urandom_range(0, 9))
                    0: pg = 16'($urandom);
                    1: pg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    default: pg = pool[$urandom_range(0, pool_sz - 1)];
                endcase
                send_ref(pg, 1'b0, '0);
            end
            i_in_valid <= 1'b0;
            wait_drained();
        end

        repeat (16) @(posedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: lru_page_replacement_core.f
src/lpr_pkg.sv
src/lpr_frame_mem.sv
src/lpr_scan_unit.sv
src/lru_page_replacement_core.sv
tb/tb_lru_page_replacement_core.sv
